// ----- sv/srfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants for the sine range fold polynomial block
// Fixed-point coefficients, widths and the item type between front and back.
// ----------------------------------------------------------------------------
package srfp_pkg;

    localparam int AngleW = 24;
    localparam int SineW  = 16;
    localparam int RW     = 32;   // Q28 residue, |r| < ~3.2*2^28
    localparam int KW     = 6;    // |k| <= 20

    localparam logic signed [32:0] InvTwoPiQ32 = 33'sd683565276;
    localparam logic signed [31:0] TwoPiQ28    = 32'sd1686629713;
    localparam logic signed [31:0] C11Q40      = -32'sd27545;
    localparam logic signed [31:0] C9Q28       = 32'sd740;
    localparam logic signed [31:0] C7Q28       = -32'sd53261;
    localparam logic signed [31:0] C5Q28       = 32'sd2236962;
    localparam logic signed [31:0] C3Q28       = -32'sd44739243;
    localparam logic signed [31:0] C1Q28       = 32'sd268435456;
    localparam logic signed [SineW-1:0] OutMax = 16'sd32767;

    // item handed from the folding front to the polynomial back
    typedef struct packed {
        logic signed [RW-1:0] r;
    } fold_item_t;

    // round(x*y / 2^sh), ties toward +inf, result truncated to 32 bits
    function automatic logic signed [31:0] rnd_shift(input logic signed [63:0] prod,
                                                      input int sh);
        logic signed [63:0] t;
        begin
            t = (prod + (64'sd1 <<< (sh - 1))) >>> sh;
            return t[31:0];
        end
    endfunction

endpackage

// ----- sv/sine_range_fold_polynomial_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_range_fold_polynomial_top: fixed-point sine
// Folds a Q7.16 angle into [-pi, pi] and evaluates an odd Taylor polynomial.
// ----------------------------------------------------------------------------
// One item per cycle: busy is never raised, so start may be high every cycle.
// Each result appears on sine with done high for one cycle. It passes two
// folding stages, one queue register and eight polynomial stages; every stage
// but the queue register and the final rounding stage holds one multiplier.
// The receiver cannot stall, and no result is ever dropped.
module sine_range_fold_polynomial_top
    import srfp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [AngleW-1:0] angle,
    output logic                     done,
    output logic signed [SineW-1:0]  sine
);

    logic       f_vld, q_vld;
    fold_item_t f_item, q_item;

    assign busy = 1'b0;

    srfp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_vld(start & ~busy), .angle(angle),
        .out_vld(f_vld), .out_item(f_item)
    );

    srfp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_vld(f_vld), .in_item(f_item),
        .out_vld(q_vld), .out_item(q_item)
    );

    srfp_back u_back (
        .clk(clk), .rst_n(rst_n), .in_vld(q_vld), .in_item(q_item),
        .out_vld(done), .sine(sine)
    );

endmodule

// ----- sv/srfp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_front: range folding
// Two-stage pipeline: k = round(angle/(2*pi)), then r = angle - k*2*pi in Q28.
// ----------------------------------------------------------------------------
module srfp_front
    import srfp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic signed [AngleW-1:0] angle,
    output logic                     out_vld,
    output fold_item_t               out_item
);

    logic                     v1_reg;
    logic signed [AngleW-1:0] a1_reg;
    logic signed [KW-1:0]     k1_reg;
    logic signed [63:0]       kprod;
    logic signed [63:0]       kfull;
    logic signed [KW-1:0]     k_next;
    logic signed [RW-1:0]     r_next;
    logic signed [47:0]       kmul;

    // quotient by reciprocal, rounded to nearest
    assign kprod  = 64'(angle) * 64'(InvTwoPiQ32);
    assign kfull  = (kprod + (64'sd1 <<< 47)) >>> 48;
    assign k_next = kfull[KW-1:0];

    // residue
    assign kmul   = 48'(k1_reg) * 48'(TwoPiQ28);
    assign r_next = RW'((48'(a1_reg) <<< 12) - kmul);

    // advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            out_vld <= 1'b0;
        end
        else
        begin
            v1_reg  <= in_vld;
            out_vld <= v1_reg;
        end
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        a1_reg     <= angle;
        k1_reg     <= k_next;
        out_item.r <= r_next;
    end

endmodule

// ----- sv/srfp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_queue: decoupling register between front and back
// One-entry pass-through queue; the back never stalls so it drains each cycle.
// ----------------------------------------------------------------------------
module srfp_queue
    import srfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_vld,
    input  fold_item_t in_item,
    output logic       out_vld,
    output fold_item_t out_item
);

    logic       vld_reg;
    fold_item_t item_reg;

    // hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    // capture item
    always_ff @(posedge clk)
    begin
        if (in_vld)
            item_reg <= in_item;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ----- sv/srfp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_back: Horner polynomial evaluation
// Eight pipeline stages: r^2, five Horner steps, p*r, round; one multiply in each but round.
// ----------------------------------------------------------------------------
module srfp_back
    import srfp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  fold_item_t              in_item,
    output logic                    out_vld,
    output logic signed [SineW-1:0] sine
);

    localparam int NSt = 7;
    localparam int R2W = 34;   // r^2 in Q28 reaches about pi^2 * 2^28 > 2^31

    logic [NSt-1:0]       v_reg;
    logic signed [31:0]   r_reg  [NSt];
    logic signed [R2W-1:0] r2_reg [NSt];
    logic signed [31:0]   p_reg  [NSt];
    logic signed [31:0]   s_next;
    logic signed [31:0]   q;
    logic signed [31:0]   coef   [5];
    logic signed [63:0]   prod   [6];
    logic signed [63:0]   r2_full;

    assign coef[0] = C9Q28;
    assign coef[1] = C7Q28;
    assign coef[2] = C5Q28;
    assign coef[3] = C3Q28;
    assign coef[4] = C1Q28;

    // per-stage products
    assign prod[0] = 64'(in_item.r) * 64'(in_item.r);
    assign prod[1] = 64'(r2_reg[0]) * 64'(C11Q40);
    genvar g;
    generate
        for (g = 2; g < 6; g = g + 1)
        begin : g_mul
            assign prod[g] = 64'(p_reg[g-1]) * 64'(r2_reg[g-1]);
        end
    endgenerate

    // square of the residue, rounded to Q28 at full width
    assign r2_full = (prod[0] + (64'sd1 <<< 27)) >>> 28;

    // advance valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            out_vld <= 1'b0;
        end
        else
        begin
            v_reg   <= {v_reg[NSt-2:0], in_vld};
            out_vld <= v_reg[NSt-1];
        end
    end

    // advance data
    always_ff @(posedge clk)
    begin
        r_reg[0]  <= in_item.r;
        r2_reg[0] <= r2_full[R2W-1:0];
        p_reg[0]  <= '0;
        r_reg[1]  <= r_reg[0];
        r2_reg[1] <= r2_reg[0];
        p_reg[1]  <= rnd_shift(prod[1], 40) + coef[0];
        for (int i = 2; i < 6; i++)
        begin
            r_reg[i]  <= r_reg[i-1];
            r2_reg[i] <= r2_reg[i-1];
            p_reg[i]  <= rnd_shift(prod[i], 28) + coef[i-1];
        end
        r_reg[6]  <= r_reg[5];
        r2_reg[6] <= r2_reg[5];
        p_reg[6]  <= s_next;
        sine      <= (q > 32'(OutMax)) ? OutMax :
                     (q < -32'(OutMax)) ? -OutMax : q[SineW-1:0];
    end

    // final multiply by r, then round to Q15
    assign s_next = rnd_shift(64'(p_reg[5]) * 64'(r_reg[5]), 28);
    assign q      = (p_reg[6] + 32'sd4096) >>> 13;

endmodule

// ----- sv/srfp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_checker: port-level checks
// Watches the top level ports for latency and range of results.
// ----------------------------------------------------------------------------
module srfp_checker
    import srfp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic signed [SineW-1:0] sine
);

    // result range never reaches -32768
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sine != -16'sd32768))
        else $error("sine out of range");

    // every accepted item yields a result
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 done)
        else $error("missing result");

    // no result without an earlier accepted item
    a_noinv: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 11))
        else $error("spurious result");

endmodule

bind sine_range_fold_polynomial_top srfp_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .sine(sine)
);
